// ----- rtl/smeu_pkg.sv -----
// package for the stack machine execute unit
// opcodes, event and error codes, payload structs, shared constants
package smeu_pkg;

    localparam int STACK_DEPTH  = 16;
    localparam int RETURN_DEPTH = 4;
    localparam int STORE_WORDS  = 256;
    localparam int OPTION_COUNT = 64;
    localparam int PC_BITS      = 16;

    localparam int SP_BITS   = $clog2(STACK_DEPTH);
    localparam int SD_BITS   = $clog2(STACK_DEPTH + 1);
    localparam int RP_BITS   = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int RD_BITS   = $clog2(RETURN_DEPTH + 1);
    localparam int SA_BITS   = $clog2(STORE_WORDS);
    localparam int OPT_BITS  = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_POP = 5'd1, OP_STR_CALL = 5'd2, OP_EMIT_INT = 5'd3,
        OP_EMIT_REF = 5'd4, OP_EMIT_LIT = 5'd5, OP_ENDL = 5'd6, OP_DISPLAY = 5'd7,
        OP_SWITCH = 5'd8, OP_READ = 5'd9, OP_LOC_STORE = 5'd10, OP_GLB_LOAD = 5'd11,
        OP_GLB_STORE = 5'd12, OP_IJUMP = 5'd13, OP_CJUMP = 5'd14, OP_CALL = 5'd15,
        OP_NEG = 5'd16, OP_NOT = 5'd17, OP_ADD = 5'd18, OP_SUB = 5'd19,
        OP_MUL = 5'd20, OP_DIV = 5'd21, OP_EQ = 5'd22, OP_NEQ = 5'd23,
        OP_LT = 5'd24, OP_LTE = 5'd25, OP_GT = 5'd26, OP_GTE = 5'd27,
        OP_AND = 5'd28, OP_OR = 5'd29, OP_EOX = 5'd30, OP_START = 5'd31
    } t_op;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_PINT = 3'd1;
    localparam logic [2:0] EV_PREF = 3'd2;
    localparam logic [2:0] EV_PLIT = 3'd3;
    localparam logic [2:0] EV_EOS  = 3'd4;
    localparam logic [2:0] EV_CALL = 3'd5;
    localparam logic [2:0] EV_SWCH = 3'd6;
    localparam logic [2:0] EV_HALT = 3'd7;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_DIV0  = 3'd3;
    localparam logic [2:0] ERR_ROVER = 3'd5;

    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] literal;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic [2:0]         event_res;
        logic signed [31:0] event_value;
        logic               event_option;
        logic [2:0]         error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EXEC, S_DIV, S_WB, S_OUT
    } t_state;

    // divider control between sequencer and divide unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/smeu_div.sv -----
// signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// depends on smeu_pkg
module smeu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smeu_pkg::t_div_req i_req,
    output smeu_pkg::t_div_rsp o_rsp
);
    import smeu_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_trial;
    logic [31:0] w_shift;

    always_comb begin
        w_shift = {r_rem[30:0], r_quo[31]};
        w_trial = {1'b0, w_shift} - {1'b0, r_dvs};
        n_quo   = {r_quo[30:0], ~w_trial[32]};
        n_rem   = w_trial[32] ? w_shift : w_trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
                r_dvs  <= i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
                r_neg  <= i_req.dividend[31] ^ i_req.divisor[31];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule

// ----- rtl/smeu_stores.sv -----
// local and global word stores with a cleared-at-reset sweep
// depends on smeu_pkg
module smeu_stores (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_sel_glb,
    input  logic [smeu_pkg::SA_BITS-1:0] i_addr,
    input  logic                         i_we,
    input  logic [31:0]                  i_wdata,
    output logic [31:0]                  o_rdata,
    output logic                         o_ready
);
    import smeu_pkg::*;

    logic [31:0] r_loc [STORE_WORDS];
    logic [31:0] r_glb [STORE_WORDS];
    logic [31:0] r_lrd, r_grd;
    logic        r_gsel;
    logic        r_clr;
    logic [SA_BITS-1:0] r_cptr;
    logic [SA_BITS-1:0] w_addr;
    logic               w_lwe, w_gwe;
    logic [31:0]        w_wd;

    // clearing pass writes both stores at the same address each cycle
    always_comb begin
        w_addr = r_clr ? r_cptr : i_addr;
        w_wd   = r_clr ? 32'd0 : i_wdata;
        w_lwe  = r_clr || (i_we && !i_sel_glb);
        w_gwe  = r_clr || (i_we && i_sel_glb);
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) r_loc[w_addr] <= w_wd;
        if (w_gwe) r_glb[w_addr] <= w_wd;
        r_lrd  <= r_loc[w_addr];
        r_grd  <= r_glb[w_addr];
        r_gsel <= i_sel_glb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_cptr <= '0;
        end else if (r_clr) begin
            r_cptr <= r_cptr + SA_BITS'(1);
            if (r_cptr == SA_BITS'(STORE_WORDS - 1)) r_clr <= 1'b0;
        end
    end

    assign o_rdata = r_gsel ? r_grd : r_lrd;
    assign o_ready = !r_clr;
endmodule

// ----- rtl/stack_machine_execute_unit.sv -----
// stack machine execute unit: one instruction per request, result in an output register
// result passes through read, execute and write back to the output register; a divide also waits
// in the divide state (bit-serial divider, one bit per cycle); the next request waits for idle
// a result still waiting on the output holds the following one in write back
// reset: synchronous; the stores are then cleared, one word per cycle across all STORE_WORDS (256)
// addresses, during which no request is accepted; depends on smeu_pkg, smeu_stores, smeu_div
module stack_machine_execute_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  smeu_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output smeu_pkg::t_out    o_out_data
);
    import smeu_pkg::*;

    t_state r_state, n_state;
    logic        r_opt_mode;
    logic [4:0]  r_op;
    logic [31:0] r_lit;
    logic [PC_BITS-1:0] r_pc;
    logic [SD_BITS-1:0] r_sd;
    logic [RD_BITS-1:0] r_rd;
    logic        r_halted;
    logic [OPTION_COUNT-1:0] r_marks;
    logic        r_out_valid;
    t_out        r_out;

    // data stack memory: two read ports for top and second
    logic [31:0] r_ds [STACK_DEPTH];
    logic [31:0] r_top, r_sec;
    logic [PC_BITS-1:0] r_rs [RETURN_DEPTH];
    logic [PC_BITS-1:0] r_rtop;

    // execute results held until write back
    logic        r_ds_we;
    logic [SP_BITS-1:0] r_ds_wa;
    logic [31:0] r_ds_wd;
    logic        r_rs_we;
    logic [RP_BITS-1:0] r_rs_wa;
    logic [PC_BITS-1:0] r_rs_wd;
    logic        r_st_we;
    t_out        r_res;
    logic [PC_BITS-1:0] r_npc;
    logic [SD_BITS-1:0] r_nsd;
    logic [RD_BITS-1:0] r_nrd;
    logic        r_nhalt;

    logic        w_in_fire, w_out_fire, w_st_ready;
    logic [31:0] w_st_rdata;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_st_ready;

    smeu_stores u_stores (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sel_glb (r_op == OP_GLB_LOAD || r_op == OP_GLB_STORE),
        .i_addr    (r_lit[SA_BITS-1:0]),
        .i_we      (r_state == S_WB && r_st_we),
        .i_wdata   (r_top),
        .o_rdata   (w_st_rdata),
        .o_ready   (w_st_ready)
    );

    assign w_div_req.start    = (r_state == S_EXEC) && (r_op == OP_DIV) && (r_sd >= SD_BITS'(2))
                                && (r_sec != 32'd0) && !r_halted;
    assign w_div_req.dividend = r_top;
    assign w_div_req.divisor  = r_sec;

    smeu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // stack memory reads in S_RD, registered for S_EXEC
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_top  <= r_ds[SP_BITS'(r_sd - SD_BITS'(1))];
            r_sec  <= r_ds[SP_BITS'(r_sd - SD_BITS'(2))];
            r_rtop <= r_rs[RP_BITS'(r_rd - RD_BITS'(1))];
        end
        if (r_state == S_WB && r_ds_we) r_ds[r_ds_wa] <= r_ds_wd;
        if (r_state == S_WB && r_rs_we) r_rs[r_rs_wa] <= r_rs_wd;
    end

    // execute: compute everything from registered operands
    logic [PC_BITS-1:0] e_npc;
    logic [SD_BITS-1:0] e_sd;
    logic [RD_BITS-1:0] e_rd;
    logic        e_halt, e_dswe, e_rswe, e_stwe, e_optev, e_mark;
    logic [SP_BITS-1:0] e_dswa;
    logic [31:0] e_dswd, e_val;
    logic [2:0]  e_ev, e_err;
    logic        e_opt;
    logic signed [31:0] s_a, s_b;
    logic [31:0] e_bin;

    always_comb begin
        s_a = r_top;
        s_b = r_sec;
        case (t_op'(r_op))
            OP_ADD:  e_bin = r_top + r_sec;
            OP_SUB:  e_bin = r_top - r_sec;
            OP_MUL:  e_bin = r_top * r_sec;
            OP_EQ:   e_bin = {31'd0, s_a == s_b};
            OP_NEQ:  e_bin = {31'd0, s_a != s_b};
            OP_LT:   e_bin = {31'd0, s_a < s_b};
            OP_LTE:  e_bin = {31'd0, s_a <= s_b};
            OP_GT:   e_bin = {31'd0, s_a > s_b};
            OP_GTE:  e_bin = {31'd0, s_a >= s_b};
            OP_AND:  e_bin = {31'd0, (r_top != 0) && (r_sec != 0)};
            OP_OR:   e_bin = {31'd0, (r_top != 0) || (r_sec != 0)};
            default: e_bin = w_div_rsp.quotient;
        endcase
    end

    always_comb begin
        e_npc = r_pc + PC_BITS'(1);
        e_sd = r_sd; e_rd = r_rd; e_halt = r_halted;
        e_dswe = 1'b0; e_dswa = '0; e_dswd = '0;
        e_rswe = 1'b0; e_stwe = 1'b0; e_mark = 1'b0;
        e_ev = EV_NONE; e_val = '0; e_err = ERR_OK; e_optev = 1'b0;
        e_opt = (r_rd == '0) ? r_opt_mode : 1'b0;
        if (r_op == OP_START) begin
            e_npc = r_lit[PC_BITS-1:0];
            e_sd = '0; e_rd = '0; e_halt = 1'b0;
        end else if (r_halted) begin
            e_npc = r_pc; e_ev = EV_HALT;
        end else begin
            case (t_op'(r_op))
                OP_PUSH, OP_READ, OP_GLB_LOAD: begin
                    if (r_sd >= SD_BITS'(STACK_DEPTH)) e_err = ERR_OVER;
                    else begin
                        e_dswe = 1'b1; e_dswa = SP_BITS'(r_sd);
                        e_dswd = (r_op == OP_PUSH) ? r_lit : w_st_rdata;
                        e_sd = r_sd + SD_BITS'(1);
                    end
                end
                OP_POP, OP_EMIT_INT, OP_EMIT_REF, OP_LOC_STORE, OP_GLB_STORE,
                OP_CJUMP: begin
                    if (r_sd == '0) e_err = ERR_UNDER;
                    else begin
                        e_sd = r_sd - SD_BITS'(1);
                        if (r_op == OP_EMIT_INT) begin
                            e_ev = EV_PINT; e_val = r_top; e_optev = 1'b1;
                        end else if (r_op == OP_EMIT_REF && r_top != 0) begin
                            e_ev = EV_PREF; e_val = r_top; e_optev = 1'b1;
                        end else if (r_op == OP_LOC_STORE || r_op == OP_GLB_STORE) begin
                            e_stwe = 1'b1;
                        end else if (r_op == OP_CJUMP && r_top == 0) begin
                            e_npc = r_lit[PC_BITS-1:0] + PC_BITS'(1);
                        end
                    end
                end
                OP_STR_CALL: begin
                    if (r_rd >= RD_BITS'(RETURN_DEPTH)) e_err = ERR_ROVER;
                    else begin
                        e_rswe = 1'b1;
                        e_rd = r_rd + RD_BITS'(1);
                        e_npc = r_lit[PC_BITS-1:0];
                    end
                end
                OP_EMIT_LIT: begin
                    e_ev = EV_PLIT; e_val = r_lit; e_optev = 1'b1;
                end
                OP_ENDL, OP_EOX: begin
                    if (r_op == OP_ENDL) begin
                        e_ev = EV_EOS; e_optev = 1'b1;
                    end
                    if (r_rd != '0) begin
                        e_npc = r_rtop; e_rd = r_rd - RD_BITS'(1);
                    end else begin
                        e_halt = 1'b1;
                        if (r_op == OP_EOX) e_ev = EV_HALT;
                    end
                end
                OP_DISPLAY: e_mark = (r_lit < 32'(OPTION_COUNT));
                OP_SWITCH: begin
                    e_ev = EV_SWCH; e_val = r_lit; e_halt = 1'b1; e_npc = r_pc;
                end
                OP_IJUMP: e_npc = r_lit[PC_BITS-1:0] + PC_BITS'(1);
                OP_CALL: begin
                    e_ev = EV_CALL; e_val = r_lit;
                end
                OP_NEG, OP_NOT: begin
                    if (r_sd == '0) e_err = ERR_UNDER;
                    else begin
                        e_dswe = 1'b1; e_dswa = SP_BITS'(r_sd - SD_BITS'(1));
                        e_dswd = (r_op == OP_NEG) ? (32'd0 - r_top) : {31'd0, r_top == 0};
                    end
                end
                default: begin
                    if (r_sd < SD_BITS'(2)) e_err = ERR_UNDER;
                    else if (r_op == OP_DIV && r_sec == 0) e_err = ERR_DIV0;
                    else begin
                        e_dswe = 1'b1; e_dswa = SP_BITS'(r_sd - SD_BITS'(2));
                        e_dswd = e_bin; e_sd = r_sd - SD_BITS'(1);
                    end
                end
            endcase
            if (e_err != ERR_OK) begin
                e_halt = 1'b1; e_npc = r_pc; e_ev = EV_HALT; e_val = '0; e_optev = 1'b0;
                e_sd = r_sd; e_rd = r_rd;
                e_dswe = 1'b0; e_rswe = 1'b0; e_stwe = 1'b0; e_mark = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_fire) n_state = S_RD;
            S_RD:   n_state = S_EXEC;
            S_EXEC: n_state = w_div_req.start ? S_DIV : S_WB;
            S_DIV:  if (w_div_rsp.done) n_state = S_WB;
            S_WB:   if (!r_out_valid || w_out_fire) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op  <= i_in_data.op;
            r_lit <= i_in_data.literal;
        end
        // latch execute results; divide result is taken when it completes
        if ((r_state == S_EXEC && !w_div_req.start) || (r_state == S_DIV && w_div_rsp.done)) begin
            r_ds_we <= e_dswe; r_ds_wa <= e_dswa; r_ds_wd <= e_dswd;
            r_rs_we <= e_rswe; r_rs_wa <= RP_BITS'(r_rd); r_rs_wd <= r_pc + PC_BITS'(1);
            r_st_we <= e_stwe;
            r_npc <= e_npc; r_nsd <= e_sd; r_nrd <= e_rd; r_nhalt <= e_halt;
            r_res.next_pc      <= 16'(e_npc);
            r_res.event_res    <= e_ev;
            r_res.event_value  <= e_val;
            r_res.event_option <= e_optev & e_opt;
            r_res.error        <= e_err;
        end
        if (r_state == S_WB && n_state == S_OUT) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_mode  <= 1'b0;
            r_pc        <= '0;
            r_sd        <= '0;
            r_rd        <= '0;
            r_halted    <= 1'b1;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_opt_mode <= i_cfg_wdata;
            if (r_state == S_EXEC && e_mark && !w_div_req.start)
                r_marks[OPT_BITS'(r_lit)] <= 1'b1;
            if (r_state == S_WB && n_state == S_OUT) begin
                r_pc <= r_npc; r_sd <= r_nsd; r_rd <= r_nrd; r_halted <= r_nhalt;
            end
            if (r_state == S_WB && n_state == S_OUT) r_out_valid <= 1'b1;
            else if (w_out_fire)                      r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stack depth never passes its bound
    a_sd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd <= SD_BITS'(STACK_DEPTH)) else $error("stack depth beyond bound");
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= RD_BITS'(RETURN_DEPTH)) else $error("return depth beyond bound");
    // an error result always comes with a halt event
    a_err_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error != ERR_OK) |-> (r_out.event_res == EV_HALT))
        else $error("error without halt");
    // a taken request is always followed by the read state
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_RD)) else $error("request taken out of idle");
endmodule
